### hw/rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared constants and the request and response types of the serial unit.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int POINTS   = 8;
    localparam int ADDR_W   = 3;
    localparam int COUNT_W  = 4;
    localparam int ENERGY_W = 32;
    localparam int LEVEL_W  = 16;
    localparam int FRAC_W   = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'd16384;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                go;
        logic [ENERGY_W-1:0] num;
        logic [ENERGY_W-1:0] den;
        logic [LEVEL_W-1:0]  left;
        logic [LEVEL_W-1:0]  right;
    } arith_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } arith_rsp_t;

endpackage

### hw/rtl/pli_table.sv
// ----------------------------------------------------------------------------
// Breakpoint table
// Energy and level memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pli_table (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [pli_pkg::ADDR_W-1:0]    wr_addr,
    input  logic [pli_pkg::ENERGY_W-1:0]  wr_energy,
    input  logic [pli_pkg::LEVEL_W-1:0]   wr_level,
    input  logic [pli_pkg::ADDR_W-1:0]    rd_addr,
    output logic [pli_pkg::ENERGY_W-1:0]  rd_energy,
    output logic [pli_pkg::LEVEL_W-1:0]   rd_level
);

    logic [pli_pkg::ENERGY_W-1:0] energy_mem [pli_pkg::POINTS];
    logic [pli_pkg::LEVEL_W-1:0]  level_mem  [pli_pkg::POINTS];
    logic [pli_pkg::ENERGY_W-1:0] rd_energy_reg;
    logic [pli_pkg::LEVEL_W-1:0]  rd_level_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            energy_mem[wr_addr] <= wr_energy;
            level_mem[wr_addr]  <= wr_level;
        end
        rd_energy_reg <= energy_mem[rd_addr];
        rd_level_reg  <= level_mem[rd_addr];
    end

    assign rd_energy = rd_energy_reg;
    assign rd_level  = rd_level_reg;

endmodule

### hw/rtl/pli_serial.sv
// ----------------------------------------------------------------------------
// Serial interpolation unit
// Bit-serial restoring divider for the fraction, then a bit-serial multiply.
// ----------------------------------------------------------------------------
module pli_serial (
    input  logic                clk,
    input  logic                rst_n,
    input  pli_pkg::arith_req_t req,
    output pli_pkg::arith_rsp_t rsp
);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_DIV  = 2'd1;
    localparam logic [1:0] A_MUL  = 2'd2;
    localparam logic [1:0] A_FIN  = 2'd3;

    localparam int QUO_W = pli_pkg::FRAC_W + 1;
    localparam int REM_W = pli_pkg::ENERGY_W + 1;
    localparam int ACC_W = pli_pkg::LEVEL_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic [1:0]                   phase_reg, phase_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [REM_W-1:0]             rem_reg, rem_next;
    logic [pli_pkg::ENERGY_W-1:0] den_reg, den_next;
    logic [QUO_W-1:0]             quo_reg, quo_next;
    logic [ACC_W-1:0]             acc_reg, acc_next;
    logic [pli_pkg::LEVEL_W-1:0]  diff_reg, diff_next;
    logic [pli_pkg::LEVEL_W-1:0]  left_reg, left_next;
    logic                         down_reg, down_next;
    logic                         done_reg, done_next;
    logic [pli_pkg::LEVEL_W-1:0]  level_reg, level_next;

    logic [REM_W-1:0]             trial;
    logic                         ge;
    logic [pli_pkg::LEVEL_W:0]    ceil_part;

    always_comb
    begin
        trial     = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
        ge        = trial >= {1'b0, den_reg};
        ceil_part = {1'b0, acc_reg[pli_pkg::FRAC_W +: pli_pkg::LEVEL_W]}
                    + {{pli_pkg::LEVEL_W{1'b0}}, (acc_reg[pli_pkg::FRAC_W-1:0] != '0)};

        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        acc_next   = acc_reg;
        diff_next  = diff_reg;
        left_next  = left_reg;
        down_next  = down_reg;
        done_next  = 1'b0;
        level_next = level_reg;

        case (phase_reg)
            A_IDLE:
            begin
                if (req.go)
                begin
                    phase_next = A_DIV;
                    cnt_next   = '0;
                    rem_next   = {1'b0, req.num};
                    den_next   = req.den;
                    quo_next   = '0;
                    left_next  = req.left;
                    down_next  = req.right < req.left;
                    diff_next  = (req.right < req.left) ? (req.left - req.right)
                                                        : (req.right - req.left);
                end
            end
            A_DIV:
            begin
                rem_next = ge ? (trial - {1'b0, den_reg}) : trial;
                quo_next = {quo_reg[QUO_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    phase_next = A_MUL;
                    cnt_next   = '0;
                    acc_next   = '0;
                end
            end
            A_MUL:
            begin
                acc_next = {acc_reg[ACC_W-2:0], 1'b0}
                           + (quo_reg[QUO_W-1] ? ACC_W'(diff_reg) : '0);
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    phase_next = A_FIN;
                end
            end
            A_FIN:
            begin
                phase_next = A_IDLE;
                done_next  = 1'b1;
                if (down_reg)
                begin
                    level_next = left_reg - ceil_part[pli_pkg::LEVEL_W-1:0];
                end
                else
                begin
                    level_next = left_reg + acc_reg[pli_pkg::FRAC_W +: pli_pkg::LEVEL_W];
                end
            end
            default:
            begin
                phase_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= A_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        quo_reg   <= quo_next;
        acc_reg   <= acc_next;
        diff_reg  <= diff_next;
        left_reg  <= left_next;
        down_reg  <= down_next;
        level_reg <= level_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.level = level_reg;

endmodule

### hw/rtl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Breakpoint table with lookup and linear interpolation of a Q2.14 level.
// ----------------------------------------------------------------------------
// A breakpoint write's result, all zeros, is strobed on done in the cycle
// after start. A query with an empty table has its result strobed in the
// cycle after start; otherwise the first and then the last table entry are
// checked, and a query at or beyond an end of the table ends there. Else the
// table is scanned entry by entry for the segment that holds the query and,
// unless the segment has zero width, the bit-serial divider, the bit-serial
// multiplier, the rounding step and the hand-back of the result follow. The
// table memory is read one entry per cycle. busy is high from the transfer
// until the result; the result is shown for exactly one cycle and cannot be
// stalled. The point count may be written while busy is low.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [pli_pkg::ADDR_W-1:0]    slot,
    input  logic [pli_pkg::ENERGY_W-1:0]  point_energy,
    input  logic [pli_pkg::LEVEL_W-1:0]   point_level,
    input  logic [pli_pkg::ENERGY_W-1:0]  query_energy,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pli_pkg::COUNT_W-1:0]   cfg_data,
    output logic                          done,
    output logic [pli_pkg::LEVEL_W-1:0]   level,
    output logic                          clamped_low,
    output logic                          clamped_high,
    output logic                          no_segment
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK0  = 3'd1;
    localparam logic [2:0] S_CHKN  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_ARITH = 3'd4;

    localparam logic [pli_pkg::COUNT_W-1:0] COUNT_MAX = pli_pkg::COUNT_W'(pli_pkg::POINTS);

    logic [2:0]                   state_reg, state_next;
    logic [pli_pkg::COUNT_W-1:0]  points_reg, points_next;
    logic [pli_pkg::COUNT_W-1:0]  n_reg, n_next;
    logic [pli_pkg::ADDR_W-1:0]   idx_reg, idx_next;
    logic [pli_pkg::ENERGY_W-1:0] q_reg, q_next;
    logic [pli_pkg::ENERGY_W-1:0] prev_e_reg, prev_e_next;
    logic [pli_pkg::LEVEL_W-1:0]  prev_l_reg, prev_l_next;
    logic                         done_reg, done_next;
    logic [pli_pkg::LEVEL_W-1:0]  level_reg, level_next;
    logic                         lo_reg, lo_next;
    logic                         hi_reg, hi_next;
    logic                         none_reg, none_next;

    logic                         accept;
    logic                         wr_en;
    logic [pli_pkg::ADDR_W-1:0]   rd_addr;
    logic [pli_pkg::ADDR_W-1:0]   last_addr;
    logic [pli_pkg::ENERGY_W-1:0] rd_energy;
    logic [pli_pkg::LEVEL_W-1:0]  rd_level;
    logic [pli_pkg::COUNT_W-1:0]  n_sat;
    pli_pkg::arith_req_t          req;
    pli_pkg::arith_rsp_t          rsp;

    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign wr_en     = accept && (op == pli_pkg::OP_WRITE);
    assign n_sat     = (points_reg > COUNT_MAX) ? COUNT_MAX : points_reg;
    assign last_addr = pli_pkg::ADDR_W'(n_reg - 1'b1);

    pli_table u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (slot),
        .wr_energy (point_energy),
        .wr_level  (point_level),
        .rd_addr   (rd_addr),
        .rd_energy (rd_energy),
        .rd_level  (rd_level)
    );

    pli_serial u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        case (state_reg)
            S_CHK0:  rd_addr = last_addr;
            S_CHKN:  rd_addr = pli_pkg::ADDR_W'(1);
            S_SCAN:  rd_addr = idx_reg + 1'b1;
            default: rd_addr = '0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        points_next = points_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        q_next      = q_reg;
        prev_e_next = prev_e_reg;
        prev_l_next = prev_l_reg;
        done_next   = 1'b0;
        level_next  = level_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        none_next   = none_reg;

        req.go    = 1'b0;
        req.num   = q_reg - prev_e_reg;
        req.den   = rd_energy - prev_e_reg;
        req.left  = prev_l_reg;
        req.right = rd_level;

        if (cfg_valid && cfg_ready)
        begin
            points_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    q_next = query_energy;
                    n_next = n_sat;
                    if (op == pli_pkg::OP_WRITE)
                    begin
                        done_next  = 1'b1;
                        level_next = '0;
                        lo_next    = 1'b0;
                        hi_next    = 1'b0;
                        none_next  = 1'b0;
                    end
                    else if (n_sat == '0)
                    begin
                        done_next  = 1'b1;
                        level_next = pli_pkg::LEVEL_ONE;
                        lo_next    = 1'b0;
                        hi_next    = 1'b0;
                        none_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CHK0;
                    end
                end
            end
            S_CHK0:
            begin
                prev_e_next = rd_energy;
                prev_l_next = rd_level;
                lo_next     = 1'b0;
                hi_next     = 1'b0;
                none_next   = 1'b0;
                level_next  = rd_level;
                if (n_reg == pli_pkg::COUNT_W'(1))
                begin
                    done_next  = 1'b1;
                    lo_next    = q_reg <= rd_energy;
                    hi_next    = q_reg >= rd_energy;
                    state_next = S_IDLE;
                end
                else if (q_reg <= rd_energy)
                begin
                    done_next  = 1'b1;
                    lo_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CHKN;
                end
            end
            S_CHKN:
            begin
                if (q_reg >= rd_energy)
                begin
                    done_next  = 1'b1;
                    level_next = rd_level;
                    hi_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = pli_pkg::ADDR_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ((q_reg >= prev_e_reg) && (q_reg <= rd_energy))
                begin
                    if (rd_energy == prev_e_reg)
                    begin
                        done_next  = 1'b1;
                        level_next = prev_l_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        req.go     = 1'b1;
                        state_next = S_ARITH;
                    end
                end
                else if (idx_reg == last_addr)
                begin
                    done_next  = 1'b1;
                    level_next = pli_pkg::LEVEL_ONE;
                    none_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next    = idx_reg + 1'b1;
                    prev_e_next = rd_energy;
                    prev_l_next = rd_level;
                end
            end
            S_ARITH:
            begin
                if (rsp.done)
                begin
                    done_next  = 1'b1;
                    level_next = rsp.level;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            points_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            points_reg <= points_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        q_reg      <= q_next;
        prev_e_reg <= prev_e_next;
        prev_l_reg <= prev_l_next;
        level_reg  <= level_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        none_reg   <= none_next;
    end

    assign done         = done_reg;
    assign level        = level_reg;
    assign clamped_low  = lo_reg;
    assign clamped_high = hi_reg;
    assign no_segment   = none_reg;

    // A result always coincides with the return to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobed while still busy");

    // A breakpoint write gives an all-zero result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == pli_pkg::OP_WRITE)) |=>
        (done && (level == '0) && !clamped_low && !clamped_high && !no_segment))
        else $error("write result missing or not zero");

    // With no segment found the level is 1.0 and no clamp flag is raised.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_segment) |->
        ((level == pli_pkg::LEVEL_ONE) && !clamped_low && !clamped_high))
        else $error("no-segment result malformed");

    // An accepted query either finishes at once or keeps the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == pli_pkg::OP_QUERY)) |=> (busy || done))
        else $error("query transfer lost");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear interpolator testbench
// A short table of directed breakpoint writes and queries, then random table
// loads and queries in phases with different point counts and sender gaps.
// Results are compared field by field with a behavioural or fixed prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          NUM_PHASES  = 8;

    typedef struct packed {
        logic [pli_pkg::LEVEL_W-1:0] level;
        logic                        clamped_low;
        logic                        clamped_high;
        logic                        no_segment;
    } interp_result_t;

    typedef struct packed {
        logic                         is_cfg;
        logic [pli_pkg::COUNT_W-1:0]  cfg_value;
        logic                         op;
        logic [pli_pkg::ADDR_W-1:0]   slot;
        logic [pli_pkg::ENERGY_W-1:0] point_energy;
        logic [pli_pkg::LEVEL_W-1:0]  point_level;
        logic [pli_pkg::ENERGY_W-1:0] query_energy;
        logic                         typed;
        interp_result_t               result;
    } directed_row_t;

    logic                         clk;
    logic                         rst_n        = 1'b0;
    logic                         start        = 1'b0;
    logic                         busy;
    logic                         op           = pli_pkg::OP_WRITE;
    logic [pli_pkg::ADDR_W-1:0]   slot         = '0;
    logic [pli_pkg::ENERGY_W-1:0] point_energy = '0;
    logic [pli_pkg::LEVEL_W-1:0]  point_level  = '0;
    logic [pli_pkg::ENERGY_W-1:0] query_energy = '0;
    logic                         cfg_valid    = 1'b0;
    logic                         cfg_ready;
    logic [pli_pkg::COUNT_W-1:0]  cfg_data     = '0;
    logic                         done;
    logic [pli_pkg::LEVEL_W-1:0]  level;
    logic                         clamped_low;
    logic                         clamped_high;
    logic                         no_segment;

    logic [pli_pkg::ENERGY_W-1:0] shadow_energy [pli_pkg::POINTS];
    logic [pli_pkg::LEVEL_W-1:0]  shadow_level [pli_pkg::POINTS];
    logic [pli_pkg::COUNT_W-1:0]  shadow_count = '0;

    interp_result_t      pending_levels [$];
    directed_row_t       directed_rows [$];
    interp_result_t      want;
    int                  error_count  = 0;
    int                  items_sent   = 0;
    int                  idle_pct     = 0;
    int unsigned         cycle_count  = 0;

    piecewise_linear_interpolator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .slot         (slot),
        .point_energy (point_energy),
        .point_level  (point_level),
        .query_energy (query_energy),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .level        (level),
        .clamped_low  (clamped_low),
        .clamped_high (clamped_high),
        .no_segment   (no_segment)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic interp_result_t predict_level(input logic [pli_pkg::ENERGY_W-1:0] q);
        interp_result_t               r;
        int                           n;
        logic                         found;
        logic [63:0]                  t;
        logic [63:0]                  p;
        logic [pli_pkg::ENERGY_W-1:0] e0;
        logic [pli_pkg::ENERGY_W-1:0] e1;
        logic [pli_pkg::LEVEL_W-1:0]  l0;
        logic [pli_pkg::LEVEL_W-1:0]  l1;
        r = '0;
        n = (shadow_count > pli_pkg::POINTS) ? pli_pkg::POINTS : int'(shadow_count);
        if (n == 0)
        begin
            r.level      = pli_pkg::LEVEL_ONE;
            r.no_segment = 1'b1;
        end
        else if (n == 1)
        begin
            r.level        = shadow_level[0];
            r.clamped_low  = (q <= shadow_energy[0]);
            r.clamped_high = (q >= shadow_energy[0]);
        end
        else if (q <= shadow_energy[0])
        begin
            r.level       = shadow_level[0];
            r.clamped_low = 1'b1;
        end
        else if (q >= shadow_energy[n-1])
        begin
            r.level        = shadow_level[n-1];
            r.clamped_high = 1'b1;
        end
        else
        begin
            found = 1'b0;
            for (int i = 0; i + 1 < n; i++)
            begin
                e0 = shadow_energy[i];
                e1 = shadow_energy[i+1];
                l0 = shadow_level[i];
                l1 = shadow_level[i+1];
                if (!found && q >= e0 && q <= e1)
                begin
                    found = 1'b1;
                    if (e1 == e0)
                        r.level = l0;
                    else
                    begin
                        t = {32'b0, q - e0} << 16;
                        t = t / {32'b0, e1 - e0};
                        if (l1 >= l0)
                        begin
                            p       = t * {48'b0, l1 - l0};
                            r.level = l0 + 16'(p >> 16);
                        end
                        else
                        begin
                            p       = t * {48'b0, l0 - l1};
                            r.level = l0 - 16'((p + 64'd65535) >> 16);
                        end
                    end
                end
            end
            if (!found)
            begin
                r.level      = pli_pkg::LEVEL_ONE;
                r.no_segment = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [pli_pkg::LEVEL_W-1:0] random_level();
        logic [pli_pkg::LEVEL_W-1:0] v;
        if ($urandom_range(0, 3) == 0)
            v = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        else
            v = 16'($urandom);
        return v;
    endfunction

    function automatic directed_row_t cfg_row(input logic [pli_pkg::COUNT_W-1:0] value);
        directed_row_t r;
        r           = '0;
        r.is_cfg    = 1'b1;
        r.cfg_value = value;
        return r;
    endfunction

    function automatic directed_row_t write_row(input logic [pli_pkg::ADDR_W-1:0] s,
                                                input logic [pli_pkg::ENERGY_W-1:0] e,
                                                input logic [pli_pkg::LEVEL_W-1:0] l);
        directed_row_t r;
        r              = '0;
        r.op           = pli_pkg::OP_WRITE;
        r.slot         = s;
        r.point_energy = e;
        r.point_level  = l;
        r.query_energy = $urandom;
        r.typed        = 1'b1;
        return r;
    endfunction

    function automatic directed_row_t query_row(input logic [pli_pkg::ENERGY_W-1:0] q,
                                                input logic typed,
                                                input logic [pli_pkg::LEVEL_W-1:0] l,
                                                input logic lo,
                                                input logic hi,
                                                input logic none);
        directed_row_t r;
        r              = '0;
        r.op           = pli_pkg::OP_QUERY;
        r.slot         = 3'($urandom);
        r.point_energy = $urandom;
        r.point_level  = 16'($urandom);
        r.query_energy = q;
        r.typed        = typed;
        r.result       = '{l, lo, hi, none};
        return r;
    endfunction

    task automatic add_row(input directed_row_t row);
        directed_rows = {directed_rows, row};
    endtask

    task automatic transfer_item(input logic op_i,
                                 input logic [pli_pkg::ADDR_W-1:0] slot_i,
                                 input logic [pli_pkg::ENERGY_W-1:0] energy_i,
                                 input logic [pli_pkg::LEVEL_W-1:0] level_i,
                                 input logic [pli_pkg::ENERGY_W-1:0] query_i,
                                 input logic typed,
                                 input interp_result_t typed_result);
        interp_result_t r;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        op           <= op_i;
        slot         <= slot_i;
        point_energy <= energy_i;
        point_level  <= level_i;
        query_energy <= query_i;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op_i == pli_pkg::OP_WRITE)
        begin
            shadow_energy[slot_i] = energy_i;
            shadow_level[slot_i]  = level_i;
            r = '0;
        end
        else
            r = predict_level(query_i);
        if (typed)
            r = typed_result;
        pending_levels = {pending_levels, r};
        items_sent++;
    endtask

    task automatic write_point_count(input logic [pli_pkg::COUNT_W-1:0] value);
        start <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_count = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic load_sorted_table();
        logic [32:0]                  acc;
        logic [pli_pkg::ENERGY_W-1:0] span;
        case ($urandom_range(0, 3))
            0:
            begin
                acc  = {1'b0, 32'($urandom)};
                span = 32'd3;
            end
            1:
            begin
                acc  = 33'($urandom_range(0, 1000));
                span = 32'h0000_FFFF;
            end
            2:
            begin
                acc  = '0;
                span = 32'h1FFF_FFFF;
            end
            default:
            begin
                acc  = {1'b0, 32'($urandom)};
                span = 32'h3FFF_FFFF;
            end
        endcase
        for (int s = 0; s < pli_pkg::POINTS; s++)
        begin
            if (s > 0 && $urandom_range(0, 3) != 0)
                acc = acc + 33'($urandom_range(0, span));
            if (acc > 33'hFFFF_FFFF)
                acc = 33'hFFFF_FFFF;
            transfer_item(pli_pkg::OP_WRITE, 3'(s), acc[31:0], random_level(), $urandom,
                          1'b0, '0);
        end
    endtask

    task automatic query_near_point();
        int                           i;
        logic [pli_pkg::ENERGY_W-1:0] lo;
        logic [pli_pkg::ENERGY_W-1:0] hi;
        logic [pli_pkg::ENERGY_W-1:0] q;
        i  = $urandom_range(0, pli_pkg::POINTS - 1);
        lo = shadow_energy[i];
        hi = shadow_energy[(i == pli_pkg::POINTS - 1) ? i : i + 1];
        if (lo > hi)
        begin
            q  = lo;
            lo = hi;
            hi = q;
        end
        case ($urandom_range(0, 5))
            0:       q = shadow_energy[i];
            1:       q = shadow_energy[i] + 32'd1;
            2:       q = shadow_energy[i] - 32'd1;
            5:       q = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
            default: q = lo + 32'($urandom_range(0, hi - lo));
        endcase
        transfer_item(pli_pkg::OP_QUERY, 3'($urandom), $urandom, 16'($urandom), q, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_levels.size() == 0)
            begin
                $error("result with nothing outstanding: level %h", level);
                error_count++;
            end
            else
            begin
                want = pending_levels.pop_front();
                if (level !== want.level)
                begin
                    $error("level: expected %h, actual %h", want.level, level);
                    error_count++;
                end
                if (clamped_low !== want.clamped_low)
                begin
                    $error("clamped_low: expected %b, actual %b", want.clamped_low,
                           clamped_low);
                    error_count++;
                end
                if (clamped_high !== want.clamped_high)
                begin
                    $error("clamped_high: expected %b, actual %b", want.clamped_high,
                           clamped_high);
                    error_count++;
                end
                if (no_segment !== want.no_segment)
                begin
                    $error("no_segment: expected %b, actual %b", want.no_segment,
                           no_segment);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int            phase_items [NUM_PHASES];
        int            phase_idle [NUM_PHASES];
        int            phase_count [NUM_PHASES];
        int            phase_first;
        directed_row_t row;

        phase_items = '{200, 200, 100, 200, 150, 250, 150, 150};
        phase_idle  = '{0, 79, 16, 0, 79, 16, 0, 79};
        phase_count = '{8, 5, 0, 15, 1, 8, 2, 3};

        // An empty table answers 1.0; the table is then filled in slot order so
        // that no query ever reads an entry left unwritten since reset.
        add_row(query_row(32'h0, 1'b1, pli_pkg::LEVEL_ONE, 1'b0, 1'b0, 1'b1));
        add_row(query_row(32'hFFFF_FFFF, 1'b1, pli_pkg::LEVEL_ONE, 1'b0, 1'b0, 1'b1));
        add_row(write_row(3'd0, 32'd1000, 16'd0));
        add_row(write_row(3'd1, 32'd2000, 16'd16384));
        add_row(write_row(3'd2, 32'd2000, 16'd32768));
        add_row(write_row(3'd3, 32'h1000_0000, 16'hFFFF));
        add_row(write_row(3'd4, 32'h8000_0000, 16'h0000));
        add_row(write_row(3'd5, 32'hFFFF_FFF0, 16'hFFFF));
        add_row(write_row(3'd6, 32'hFFFF_FFFF, 16'h0001));
        add_row(write_row(3'd7, 32'hFFFF_FFFF, 16'hAAAA));
        add_row(cfg_row(4'd1));
        add_row(query_row(32'd1000, 1'b1, 16'd0, 1'b1, 1'b1, 1'b0));
        add_row(query_row(32'h0, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0));
        add_row(query_row(32'hFFFF_FFFF, 1'b1, 16'd0, 1'b0, 1'b1, 1'b0));
        add_row(cfg_row(4'd15));
        add_row(query_row(32'h0, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0));
        add_row(query_row(32'hFFFF_FFFF, 1'b1, 16'hAAAA, 1'b0, 1'b1, 1'b0));
        add_row(query_row(32'd1500, 1'b0, '0, 1'b0, 1'b0, 1'b0));
        add_row(query_row(32'd2000, 1'b0, '0, 1'b0, 1'b0, 1'b0));
        add_row(query_row(32'h4000_0000, 1'b0, '0, 1'b0, 1'b0, 1'b0));
        add_row(query_row(32'hFFFF_FFF8, 1'b0, '0, 1'b0, 1'b0, 1'b0));
        add_row(cfg_row(4'd2));
        add_row(query_row(32'd1999, 1'b0, '0, 1'b0, 1'b0, 1'b0));
        add_row(query_row(32'd2000, 1'b1, 16'd16384, 1'b0, 1'b1, 1'b0));
        add_row(query_row(32'd1001, 1'b0, '0, 1'b0, 1'b0, 1'b0));
        add_row(write_row(3'd1, 32'd500, 16'd7));
        add_row(query_row(32'd700, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0));

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.is_cfg)
                write_point_count(row.cfg_value);
            else
                transfer_item(row.op, row.slot, row.point_energy, row.point_level,
                              row.query_energy, row.typed, row.result);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_point_count(4'(phase_count[p]));
            idle_pct    = phase_idle[p];
            phase_first = items_sent;
            while (items_sent - phase_first < phase_items[p])
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        load_sorted_table();
                        repeat ($urandom_range(4, 12))
                            query_near_point();
                    end
                    6, 7:
                    begin
                        repeat ($urandom_range(1, 3))
                            transfer_item(pli_pkg::OP_WRITE, 3'($urandom), $urandom,
                                          random_level(), $urandom, 1'b0, '0);
                    end
                    default:
                    begin
                        repeat ($urandom_range(1, 4))
                            transfer_item(pli_pkg::OP_QUERY, 3'($urandom), $urandom,
                                          16'($urandom), $urandom, 1'b0, '0);
                    end
                endcase
            end
        end

        start <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/pli_pkg.sv
hw/rtl/pli_table.sv
hw/rtl/pli_serial.sv
hw/rtl/piecewise_linear_interpolator.sv
sim/tb_top.sv
